// ----- design/led_display_frame_serializer_unit_assert.svh -----
// Assertion macros for the LED frame serializer.
// Each macro takes a label, clock, reset, antecedent, consequent and message.
`ifndef LED_DISPLAY_FRAME_SERIALIZER_UNIT_ASSERT_SVH
`define LED_DISPLAY_FRAME_SERIALIZER_UNIT_ASSERT_SVH

`ifndef SYNTH
`define LDFS_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);
`define LDFS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LDFS_ASSERT_SAME(lbl, ck, rs, ante, cons, msg)
`define LDFS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif

`endif

// ----- design/ldfs_pkg.sv -----
`default_nettype none

package ldfs_pkg;

  localparam int NUM_DIGITS = 16;
  localparam int BUF_AW     = 4;
  localparam int POS_W      = 5;

  localparam logic [7:0] CMD_DATA  = 8'h40;
  localparam logic [7:0] CMD_ADDR  = 8'hC0;
  localparam logic [7:0] CTRL_BASE = 8'h80;

  // byte positions within one refresh
  localparam logic [POS_W-1:0] POS_ADDR_CMD = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CTRL     = POS_W'(NUM_DIGITS + 2);
  localparam logic [POS_W-1:0] POS_END      = POS_W'(NUM_DIGITS + 3);

  localparam logic REG_BRIGHTNESS = 1'b0;
  localparam logic REG_DISPLAY_ON = 1'b1;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_START = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef struct packed {
    logic              wr;
    logic              clr;
    logic [BUF_AW-1:0] addr;
    logic [7:0]        data;
  } buf_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic busy;
    logic data_line;
    logic clock_line;
  } line_status_t;

endpackage

`default_nettype wire

// ----- design/ldfs_buffer.sv -----
`default_nettype none

module ldfs_buffer (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire ldfs_pkg::buf_cmd_t      cmd,
  input  wire logic [ldfs_pkg::BUF_AW-1:0] rd_addr,
  output logic [7:0]                   rd_data
);
  import ldfs_pkg::*;

  logic [7:0] mem [NUM_DIGITS];

  // clear is a parallel wipe of all entries
  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        mem[i] <= '0;
      end
    end else if (cmd.wr) begin
      mem[cmd.addr] <= cmd.data;
    end
  end

  assign rd_data = mem[rd_addr];

endmodule

`default_nettype wire

// ----- design/ldfs_sequencer.sv -----
`default_nettype none

module ldfs_sequencer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire ldfs_pkg::func_t             func,
  input  wire logic [ldfs_pkg::BUF_AW-1:0] digit_index,
  input  wire logic [7:0]                  digit_value,
  input  wire logic [2:0]                  brightness,
  input  wire logic                        display_on,
  input  wire logic [7:0]                  rd_data,
  output logic [ldfs_pkg::BUF_AW-1:0]      rd_addr,
  output ldfs_pkg::buf_cmd_t               buf_cmd,
  output ldfs_pkg::line_status_t           status
);
  import ldfs_pkg::*;

  typedef enum logic [2:0] {
    PH_START_DATA = 3'd0,
    PH_START_CLK  = 3'd1,
    PH_BIT_DATA   = 3'd2,
    PH_BIT_HIGH   = 3'd3,
    PH_BIT_LOW    = 3'd4,
    PH_STOP_DATA  = 3'd5,
    PH_STOP_CLK   = 3'd6,
    PH_STOP_END   = 3'd7
  } phase_t;

  phase_t           phase, phase_next;
  logic [POS_W-1:0] byte_pos, byte_pos_next, pos_inc;
  logic [2:0]       bit_pos, bit_pos_next;
  logic [7:0]       shift_byte, shift_byte_next, byte_sel, byte_cur;
  logic             clock_level, clock_level_next;
  logic             data_level, data_level_next;
  logic             sending, sending_next;
  logic             done;

  assign rd_addr = BUF_AW'(byte_pos - POS_W'(2));
  assign pos_inc = byte_pos + POS_W'(1);

  // byte that goes out at the current position
  always_comb begin
    if (byte_pos == '0) begin
      byte_sel = CMD_DATA;
    end else if (byte_pos == POS_ADDR_CMD) begin
      byte_sel = CMD_ADDR;
    end else if (byte_pos < POS_CTRL) begin
      byte_sel = rd_data;
    end else begin
      byte_sel = CTRL_BASE | {4'b0, display_on, brightness};
    end
    byte_cur = (bit_pos == '0) ? byte_sel : shift_byte;
  end

  always_comb begin
    phase_next       = phase;
    byte_pos_next    = byte_pos;
    bit_pos_next     = bit_pos;
    shift_byte_next  = shift_byte;
    clock_level_next = clock_level;
    data_level_next  = data_level;
    sending_next     = sending;
    done             = 1'b0;
    buf_cmd.wr       = 1'b0;
    buf_cmd.clr      = 1'b0;
    buf_cmd.addr     = digit_index;
    buf_cmd.data     = digit_value;
    if (step) begin
      case (func)
        FUNC_TICK: begin
          if (sending) begin
            case (phase)
              PH_START_DATA: begin
                data_level_next = 1'b0;
                phase_next      = PH_START_CLK;
              end
              PH_START_CLK: begin
                clock_level_next = 1'b0;
                bit_pos_next     = '0;
                phase_next       = PH_BIT_DATA;
              end
              PH_BIT_DATA: begin
                shift_byte_next = byte_cur;
                data_level_next = byte_cur[0];
                phase_next      = PH_BIT_HIGH;
              end
              PH_BIT_HIGH: begin
                clock_level_next = 1'b1;
                phase_next       = PH_BIT_LOW;
              end
              PH_BIT_LOW: begin
                clock_level_next = 1'b0;
                shift_byte_next  = shift_byte >> 1;
                if (bit_pos == 3'd7) begin
                  bit_pos_next  = '0;
                  byte_pos_next = pos_inc;
                  // stop after the first command and after the last byte of a transfer
                  if (pos_inc == POS_ADDR_CMD || pos_inc >= POS_CTRL) begin
                    phase_next = PH_STOP_DATA;
                  end else begin
                    phase_next = PH_BIT_DATA;
                  end
                end else begin
                  bit_pos_next = bit_pos + 3'd1;
                  phase_next   = PH_BIT_DATA;
                end
              end
              PH_STOP_DATA: begin
                data_level_next = 1'b0;
                phase_next      = PH_STOP_CLK;
              end
              PH_STOP_CLK: begin
                clock_level_next = 1'b1;
                phase_next       = PH_STOP_END;
              end
              default: begin
                data_level_next = 1'b1;
                if (byte_pos >= POS_END) begin
                  sending_next  = 1'b0;
                  byte_pos_next = '0;
                  done          = 1'b1;
                end
                phase_next = PH_START_DATA;
              end
            endcase
          end
        end
        FUNC_WRITE: begin
          if (!sending && ({1'b0, digit_index} < (BUF_AW + 1)'(NUM_DIGITS))) begin
            buf_cmd.wr = 1'b1;
          end
        end
        default: begin
          if (!sending) begin
            buf_cmd.clr   = (func == FUNC_CLEAR);
            sending_next  = 1'b1;
            phase_next    = PH_START_DATA;
            byte_pos_next = '0;
            bit_pos_next  = '0;
          end
        end
      endcase
    end
  end

  assign status.clock_line = clock_level_next;
  assign status.data_line  = data_level_next;
  assign status.busy       = sending_next;
  assign status.frame_done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START_DATA;
      byte_pos    <= '0;
      bit_pos     <= '0;
      shift_byte  <= '0;
      clock_level <= 1'b1;
      data_level  <= 1'b1;
      sending     <= 1'b0;
    end else begin
      phase       <= phase_next;
      byte_pos    <= byte_pos_next;
      bit_pos     <= bit_pos_next;
      shift_byte  <= shift_byte_next;
      clock_level <= clock_level_next;
      data_level  <= data_level_next;
      sending     <= sending_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/led_display_frame_serializer_unit.sv -----
// Channel  | Signals                         | Content
// ---------+---------------------------------+---------------------------------------
// s_axis   | tvalid tready tdata[15:0] tuser | item: func, digit index, digit value
// m_axis   | tvalid tready tdata[7:0] tlast  | line levels, busy, frame end on tlast
// cfg      | cfg_wr_en cfg_index cfg_wdata   | brightness (0), display_on (1)
//
// One item per cycle sustained while the result side takes results. Each item
// passes an input register, one pass of the phase sequencer, and the result
// register. Synchronous reset restores idle lines, control 0x8F, empty buffer.
// A stalled result holds the result register; the input register keeps taking
// an item while the result register is full but about to be taken.
`default_nettype none
`include "led_display_frame_serializer_unit_assert.svh"

module led_display_frame_serializer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // input item stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [3:0] digit_index, [11:4] digit_value
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] func
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [0] clock_line, [1] data_line, [2] busy_res
  output logic             m_axis_tlast,   // frame_done
  // configuration writes
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [2:0]  cfg_wdata
);
  import ldfs_pkg::*;

  // configuration registers
  logic [2:0] brightness;
  logic       display_on;

  // input register
  logic              in_valid;
  func_t             in_func;
  logic [BUF_AW-1:0] in_index;
  logic [7:0]        in_value;

  // result register
  logic         out_valid;
  line_status_t out_status;

  logic              step;
  logic              s_xfer;
  buf_cmd_t          buf_cmd;
  logic [BUF_AW-1:0] rd_addr;
  logic [7:0]        rd_data;
  line_status_t      status;

  // the held item moves into the result register when that register is empty or being taken
  assign step          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= 3'd7;
      display_on <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BRIGHTNESS: brightness <= cfg_wdata;
        REG_DISPLAY_ON: display_on <= cfg_wdata[0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_xfer) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      in_func  <= func_t'(s_axis_tuser);
      in_index <= s_axis_tdata[BUF_AW-1:0];
      in_value <= s_axis_tdata[BUF_AW+7:BUF_AW];
    end
  end

  ldfs_buffer u_buffer (
    .clk     (clk),
    .rst     (rst),
    .cmd     (buf_cmd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ldfs_sequencer u_sequencer (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .func        (in_func),
    .digit_index (in_index),
    .digit_value (in_value),
    .brightness  (brightness),
    .display_on  (display_on),
    .rd_data     (rd_data),
    .rd_addr     (rd_addr),
    .buf_cmd     (buf_cmd),
    .status      (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_status <= status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_status.busy, out_status.data_line, out_status.clock_line};
  assign m_axis_tlast  = out_status.frame_done;

  // frame end always leaves the block idle
  `LDFS_ASSERT_SAME(a_done_idle, clk, rst, m_axis_tvalid && m_axis_tlast, !m_axis_tdata[2], "frame end reported while busy")
  // idle means both lines parked high
  `LDFS_ASSERT_SAME(a_idle_lines, clk, rst, m_axis_tvalid && !m_axis_tdata[2], m_axis_tdata[1] && m_axis_tdata[0], "lines not idle high while not busy")
  // an empty result register never blocks the input side
  `LDFS_ASSERT_SAME(a_ready_empty, clk, rst, !out_valid, s_axis_tready, "input stalled with empty result register")
  // a held item not yet processed is not dropped
  `LDFS_ASSERT_NEXT(a_hold_item, clk, rst, in_valid && !step, in_valid, "pending item lost")

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

// Block-level bench for the two-wire LED frame serializer.
// A cycle-free model of the line sequencer runs beside the block. It is fed
// with every accepted input transfer, and its line levels, busy flag and
// frame-end flag are queued and compared with each result transfer in order.
module testbench;
  import ldfs_pkg::*;

  // line sequencer phases, one per tick
  typedef enum logic [2:0] {
    LP_START_DATA = 3'd0,
    LP_START_CLK  = 3'd1,
    LP_BIT_DATA   = 3'd2,
    LP_BIT_HIGH   = 3'd3,
    LP_BIT_LOW    = 3'd4,
    LP_STOP_DATA  = 3'd5,
    LP_STOP_CLK   = 3'd6,
    LP_STOP_END   = 3'd7
  } line_phase_e;

  // status words, bits from the top: frame_done, busy, data_line, clock_line
  localparam line_status_t ST_IDLE     = 4'b0011; // idle, both lines high
  localparam line_status_t ST_ARMED    = 4'b0111; // refresh armed, lines untouched
  localparam line_status_t ST_SDA_LOW  = 4'b0101; // first half of start condition
  localparam line_status_t ST_BOTH_LOW = 4'b0100; // start condition complete

  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    func_t        func;
    logic [3:0]   idx;
    logic [7:0]   val;
    logic         fixed;    // 1: use exp below, 0: take the sequencer model
    line_status_t exp;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = FUNC_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = REG_BRIGHTNESS;
  logic [2:0]  cfg_wdata = '0;

  led_display_frame_serializer_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [3:0] digit_index, [11:4] digit_value
    .s_axis_tuser  (s_axis_tuser),   // [1:0] func
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [0] clock_line, [1] data_line, [2] busy_res
    .m_axis_tlast  (m_axis_tlast),   // frame_done
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Sequencer model: its own copy of buffer, registers and line state.
  // ---------------------------------------------------------------------
  logic [7:0]       seg_mem [NUM_DIGITS];
  line_phase_e      lp;
  logic [POS_W-1:0] byte_cnt;
  logic [2:0]       bit_cnt;
  logic [7:0]       shreg;
  logic             scl, sda, refresh_on;
  logic [2:0]       m_bright;
  logic             m_disp_on;

  line_status_t line_status_q [$];   // expected status per accepted transfer

  int errors     = 0;
  int items_sent = 0;
  int burst_left = 0;
  int gapless    = 0;    // transfers offered back to back, no sender gaps
  bit hold_req   = 1'b0; // ask the result side for a long stall

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("%0t: timeout, results still outstanding: %0d", $time, line_status_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // Byte that goes out at a given position of the refresh.
  function automatic logic [7:0] frame_byte(input logic [POS_W-1:0] pos);
    if (pos == '0)
      return CMD_DATA;
    if (pos == POS_ADDR_CMD)
      return CMD_ADDR;
    if (pos < POS_CTRL)
      return seg_mem[BUF_AW'(pos - POS_W'(2))];
    // control byte, taken from the registers as its first bit leaves
    return CTRL_BASE | {4'b0, m_disp_on, m_bright};
  endfunction

  // Applies one item to the model and returns the status it should produce.
  task automatic serial_step(input func_t f, input logic [3:0] idx,
                             input logic [7:0] val, output line_status_t st);
    logic done;
    done = 1'b0;
    if (f == FUNC_TICK) begin
      if (refresh_on) begin
        case (lp)
          LP_START_DATA: begin
            sda = 1'b0;
            lp  = LP_START_CLK;
          end
          LP_START_CLK: begin
            scl     = 1'b0;
            bit_cnt = '0;
            lp      = LP_BIT_DATA;
          end
          LP_BIT_DATA: begin
            if (bit_cnt == '0)
              shreg = frame_byte(byte_cnt);
            sda = shreg[0];
            lp  = LP_BIT_HIGH;
          end
          LP_BIT_HIGH: begin
            scl = 1'b1;
            lp  = LP_BIT_LOW;
          end
          LP_BIT_LOW: begin
            scl   = 1'b0;
            shreg = shreg >> 1;
            if (bit_cnt == 3'd7) begin
              bit_cnt  = '0;
              byte_cnt = byte_cnt + 1'b1;
              // stop after 0x40 and after the last buffer byte / control byte
              if (byte_cnt == POS_ADDR_CMD || byte_cnt >= POS_CTRL)
                lp = LP_STOP_DATA;
              else
                lp = LP_BIT_DATA;
            end else begin
              bit_cnt = bit_cnt + 1'b1;
              lp      = LP_BIT_DATA;
            end
          end
          LP_STOP_DATA: begin
            sda = 1'b0;
            lp  = LP_STOP_CLK;
          end
          LP_STOP_CLK: begin
            scl = 1'b1;
            lp  = LP_STOP_END;
          end
          default: begin
            sda = 1'b1;
            if (byte_cnt >= POS_END) begin
              refresh_on = 1'b0;
              byte_cnt   = '0;
              done       = 1'b1;
            end
            lp = LP_START_DATA;
          end
        endcase
      end
    end else if (!refresh_on) begin
      // writes, starts and clears only land while idle
      if (f == FUNC_WRITE) begin
        seg_mem[idx] = val;
      end else begin
        if (f == FUNC_CLEAR)
          foreach (seg_mem[i]) seg_mem[i] = '0;
        refresh_on = 1'b1;
        lp         = LP_START_DATA;
        byte_cnt   = '0;
        bit_cnt    = '0;
      end
    end
    st.frame_done = done;
    st.busy       = refresh_on;
    st.data_line  = sda;
    st.clock_line = scl;
  endtask

  // ---------------------------------------------------------------------
  // Input side: bursts of random length with random gaps between them.
  // Called right after a rising edge; returns right after the accepting edge.
  // ---------------------------------------------------------------------
  task automatic offer_item(input func_t f, input logic [3:0] idx, input logic [7:0] val,
                            input logic use_fixed, input line_status_t fixed_st);
    line_status_t st;
    int gap;
    if (gapless == 0 && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (gapless > 0)
      gapless--;
    else
      burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {4'b0, val, idx};
    do
      @(posedge clk);
    while (!s_axis_tready);
    items_sent++;
    serial_step(f, idx, val, st);
    line_status_q.push_back(use_fixed ? fixed_st : st);
  endtask

  // Sender pauses until every result is back, plus the block's latency.
  task automatic settle_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (line_status_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; only called with the pipeline drained.
  task automatic write_reg(input logic idx, input logic [2:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == REG_BRIGHTNESS)
      m_bright = val;
    else
      m_disp_on = val[0];
  endtask

  // Loads the buffer (when idle), arms a refresh and ticks it to the end,
  // with stray items mixed in. Also drops in a mid-frame register write
  // and one long result-side stall at random points.
  task automatic run_refresh_episode(input int ep);
    int n_wr, k, cfg_at, hold_at;
    func_t f;
    settle_results();
    case (ep)
      0: begin
        write_reg(REG_BRIGHTNESS, 3'd0);
        write_reg(REG_DISPLAY_ON, 3'd0);
      end
      1: begin
        write_reg(REG_BRIGHTNESS, 3'd7);
        write_reg(REG_DISPLAY_ON, 3'd1);
      end
      default: begin
        write_reg(REG_BRIGHTNESS, 3'($urandom));
        write_reg(REG_DISPLAY_ON, 3'($urandom));
      end
    endcase
    if (!refresh_on) begin
      n_wr = $urandom_range(2, 20);
      repeat (n_wr)
        offer_item(FUNC_WRITE, 4'($urandom), 8'($urandom), 1'b0, ST_IDLE);
      repeat ($urandom_range(0, 3))
        offer_item(FUNC_TICK, 4'($urandom), 8'($urandom), 1'b0, ST_IDLE);
      f = (ep == 1 || $urandom_range(0, 3) == 0) ? FUNC_CLEAR : FUNC_START;
      offer_item(f, 4'($urandom), 8'($urandom), 1'b0, ST_IDLE);
    end
    cfg_at  = $urandom_range(0, 460);
    hold_at = $urandom_range(0, 460);
    k = 0;
    while (refresh_on) begin
      if (k == cfg_at) begin
        // register change with the frame in flight
        settle_results();
        if ($urandom_range(0, 1) == 0)
          write_reg(REG_BRIGHTNESS, 3'($urandom));
        else
          write_reg(REG_DISPLAY_ON, 3'($urandom));
      end
      if (k == hold_at) begin
        hold_req = 1'b1;
        gapless  = 60;   // keep offering so the block backs up
      end
      if ($urandom_range(0, 7) == 0)
        f = func_t'(2'($urandom_range(1, 3)));
      else
        f = FUNC_TICK;
      offer_item(f, 4'($urandom), 8'($urandom), 1'b0, ST_IDLE);
      k++;
    end
    repeat ($urandom_range(1, 4))
      offer_item(FUNC_TICK, 4'($urandom), 8'($urandom), 1'b0, ST_IDLE);
  endtask

  // Directed rows: reset state, address extremes, arming, ignored items
  // while busy, then the first bit phases of the command byte.
  stim_row_t dir_rows [0:20] = '{
    '{FUNC_TICK,  4'd0,  8'h00, 1'b1, ST_IDLE},     // tick while idle
    '{FUNC_WRITE, 4'd0,  8'hFF, 1'b1, ST_IDLE},
    '{FUNC_WRITE, 4'd15, 8'h00, 1'b1, ST_IDLE},
    '{FUNC_WRITE, 4'd15, 8'hA5, 1'b1, ST_IDLE},
    '{FUNC_WRITE, 4'd10, 8'h5A, 1'b1, ST_IDLE},
    '{FUNC_TICK,  4'd5,  8'h33, 1'b1, ST_IDLE},
    '{FUNC_START, 4'd0,  8'h00, 1'b1, ST_ARMED},    // only arms, lines still high
    '{FUNC_TICK,  4'd0,  8'h00, 1'b1, ST_SDA_LOW},
    '{FUNC_WRITE, 4'd0,  8'h00, 1'b1, ST_SDA_LOW},  // write while busy: dropped
    '{FUNC_START, 4'd0,  8'h00, 1'b1, ST_SDA_LOW},  // start while busy: dropped
    '{FUNC_CLEAR, 4'd0,  8'h00, 1'b1, ST_SDA_LOW},  // clear while busy: buffer kept
    '{FUNC_TICK,  4'd0,  8'h00, 1'b1, ST_BOTH_LOW},
    '{FUNC_TICK,  4'd0,  8'h00, 1'b0, 4'b0},
    '{FUNC_TICK,  4'd0,  8'h00, 1'b0, 4'b0},
    '{FUNC_TICK,  4'd0,  8'h00, 1'b0, 4'b0},
    '{FUNC_TICK,  4'd0,  8'h00, 1'b0, 4'b0},
    '{FUNC_TICK,  4'd0,  8'h00, 1'b0, 4'b0},
    '{FUNC_TICK,  4'd0,  8'h00, 1'b0, 4'b0},
    '{FUNC_TICK,  4'd0,  8'h00, 1'b0, 4'b0},
    '{FUNC_TICK,  4'd0,  8'h00, 1'b0, 4'b0},
    '{FUNC_TICK,  4'd0,  8'h00, 1'b0, 4'b0}
  };

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : main_seq
    int ep, wait_cnt;
    // model reset: idle lines, control 0x8F, empty buffer
    foreach (seg_mem[i]) seg_mem[i] = '0;
    lp = LP_START_DATA;
    byte_cnt = '0;
    bit_cnt = '0;
    shreg = '0;
    scl = 1'b1;
    sda = 1'b1;
    refresh_on = 1'b0;
    m_bright = 3'd7;
    m_disp_on = 1'b1;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r])
      offer_item(dir_rows[r].func, dir_rows[r].idx, dir_rows[r].val,
                 dir_rows[r].fixed, dir_rows[r].exp);

    // random part: the directed frame is finished by the first episode
    ep = 0;
    while (items_sent < 800) begin
      run_refresh_episode(ep);
      ep++;
    end

    s_axis_tvalid <= 1'b0;
    wait_cnt = 0;
    while (line_status_q.size() != 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (8) @(posedge clk);
    if (line_status_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, line_status_q.size());
      errors++;
    end
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side: stall pattern in modes, plus a long hold on request.
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int hold_left, mode, mode_left, ratio_cnt;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    ratio_cnt = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      ratio_cnt++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0:       m_axis_tready <= 1'b1;                        // no stalls
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= (ratio_cnt % 3 == 0);
          default: m_axis_tready <= ($urandom_range(0, 9) < 4);
        endcase
      end
      @(posedge clk);
    end
  end

  // Every result transfer is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    line_status_t want, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tlast, m_axis_tdata[2], m_axis_tdata[1], m_axis_tdata[0]};
      if (line_status_q.size() == 0) begin
        $display("%0t: result with nothing expected: clk %b data %b busy %b done %b",
                 $time, got.clock_line, got.data_line, got.busy, got.frame_done);
        errors++;
      end else begin
        want = line_status_q.pop_front();
        if (got !== want) begin
          $display({"%0t: mismatch exp clk %b data %b busy %b done %b,",
                    " got clk %b data %b busy %b done %b"}, $time,
                   want.clock_line, want.data_line, want.busy, want.frame_done,
                   got.clock_line, got.data_line, got.busy, got.frame_done);
          errors++;
        end
      end
    end
  end

endmodule

// ----- sim.f -----
+incdir+design
design/ldfs_pkg.sv
design/ldfs_buffer.sv
design/ldfs_sequencer.sv
design/led_display_frame_serializer_unit.sv
verif/testbench.sv
